### design/etok_pkg.sv
// Shared types, codes and constants of the expression tokenizer.
package etok_pkg;

  localparam int unsigned MAX_TEXT_LENGTH = 65536;
  localparam int unsigned POS_LIMIT_INT =
    (MAX_TEXT_LENGTH - 1 > 65535) ? 65535 : MAX_TEXT_LENGTH - 1;
  localparam logic [15:0] POS_LIMIT  = 16'(POS_LIMIT_INT);
  localparam logic [15:0] SAT16      = 16'hFFFF;
  localparam logic [30:0] INT_MAX31  = 31'h7FFF_FFFF;
  localparam logic [39:0] KW_IF      = 40'h00_0000_6966;
  localparam logic [39:0] KW_WHILE   = 40'h77_6869_6C65;
  localparam logic [15:0] KW_IF_LEN    = 16'd2;
  localparam logic [15:0] KW_WHILE_LEN = 16'd5;
  localparam logic [2:0]  QUEUE_DEPTH  = 3'd4;

  // scan modes
  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_NUM  = 3'd1;
  localparam logic [2:0] MODE_WORD = 3'd2;
  localparam logic [2:0] MODE_EQ   = 3'd3;
  localparam logic [2:0] MODE_LT   = 3'd4;
  localparam logic [2:0] MODE_GT   = 3'd5;
  localparam logic [2:0] MODE_BANG = 3'd6;

  // token kinds
  localparam logic [4:0] TK_EOF     = 5'd0;
  localparam logic [4:0] TK_INT     = 5'd1;
  localparam logic [4:0] TK_IDENT   = 5'd2;
  localparam logic [4:0] TK_IF      = 5'd3;
  localparam logic [4:0] TK_WHILE   = 5'd4;
  localparam logic [4:0] TK_PLUS    = 5'd5;
  localparam logic [4:0] TK_MINUS   = 5'd6;
  localparam logic [4:0] TK_MUL     = 5'd7;
  localparam logic [4:0] TK_DIV     = 5'd8;
  localparam logic [4:0] TK_LPAREN  = 5'd9;
  localparam logic [4:0] TK_RPAREN  = 5'd10;
  localparam logic [4:0] TK_COLON   = 5'd11;
  localparam logic [4:0] TK_EE      = 5'd12;
  localparam logic [4:0] TK_EQ      = 5'd13;
  localparam logic [4:0] TK_LE      = 5'd14;
  localparam logic [4:0] TK_LT      = 5'd15;
  localparam logic [4:0] TK_GE      = 5'd16;
  localparam logic [4:0] TK_GT      = 5'd17;
  localparam logic [4:0] TK_NE      = 5'd18;
  localparam logic [4:0] TK_NEWLINE = 5'd19;
  localparam logic [4:0] TK_ERROR   = 5'd20;

  // characters
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_GREAT  = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [30:0] int_value;
    logic [15:0] ident_start;
    logic [15:0] ident_length;
    logic [15:0] line_number;
    logic        last_of_run;
  } tok_t;

  function automatic tok_t mk_tok(logic [4:0] kind, logic [30:0] val, logic [15:0] start,
                                  logic [15:0] len, logic [15:0] line_no);
    tok_t t;
    t.token_kind   = kind;
    t.int_value    = val;
    t.ident_start  = start;
    t.ident_length = len;
    t.line_number  = line_no;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

endpackage

### design/etok_in_if.sv
// Character channel of the expression tokenizer.
interface etok_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] char_byte;

  modport source(output valid, action, char_byte, input ready);
  modport sink(input valid, action, char_byte, output ready);
endinterface

### design/etok_out_if.sv
// Token channel of the expression tokenizer.
interface etok_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [30:0] int_value;
  logic [15:0] ident_start;
  logic [15:0] ident_length;
  logic [15:0] line_number;
  logic        last_of_run;

  modport source(output valid, token_kind, int_value, ident_start, ident_length,
                 line_number, last_of_run, input ready);
  modport sink(input valid, token_kind, int_value, ident_start, ident_length,
               line_number, last_of_run, output ready);
endinterface

### design/expression_tokenizer_unit.sv
// Top level of the expression tokenizer: scanner state and token queue.
//
// Channels: text (sink) takes one beat per source character, or an
// end-of-text beat with action high. tokens (source) gives one beat per
// token; last_of_run marks the final token caused by one text beat.
// A text beat gives zero, one or two tokens.
// A token pushed into an empty queue is valid the cycle after acceptance.
// Throughput: one text beat per cycle while the token side keeps up; every
// token takes one output beat of its own, even when one beat gives two
// tokens. A four-entry token queue decouples the sides: text.ready
// is high while the queue holds two tokens or fewer.
// Stall: when tokens.ready is low the queue fills and text.ready drops; no
// token is lost or repeated.
// Reset (rst, synchronous): queue empty, scan mode idle, position 0,
// line 1, error flag clear. After an ERROR token every later beat gives
// one ERROR token until reset.
module expression_tokenizer_unit (
  input logic         clk,
  input logic         rst,
  etok_in_if.sink     text,
  etok_out_if.source  tokens
);

  logic [2:0]  mode, mode_next;
  logic [30:0] acc, acc_next;
  logic [15:0] wstart, wstart_next;
  logic [15:0] wlen, wlen_next;
  logic [39:0] kw, kw_next;
  logic [15:0] pos, pos_next;
  logic [15:0] line_cnt, line_cnt_next;
  logic        err, err_next;

  etok_pkg::tok_t q [4];
  etok_pkg::tok_t q_next [4];
  logic [2:0] count, count_next;

  etok_pkg::tok_t fl_tok, tok_a, tok_b, r0, r1;
  logic fl_valid, fl_bang, va, vb, push0, push1;
  logic is_digit, is_alpha, extend;
  logic [7:0] c;
  logic [3:0] digit;
  logic [34:0] num_sum;
  logic accept, pop;
  logic [2:0] base_cnt;

  assign accept = text.valid && text.ready;
  assign pop    = tokens.ready && (count != 3'd0);
  assign text.ready = (count < 3'd3);

  assign c        = text.char_byte;
  assign digit    = c[3:0];
  assign is_digit = (c >= etok_pkg::CH_ZERO) && (c <= etok_pkg::CH_NINE);
  assign is_alpha = c inside {[etok_pkg::CH_LOW_A:etok_pkg::CH_LOW_Z],
                              [etok_pkg::CH_UP_A:etok_pkg::CH_UP_Z], etok_pkg::CH_UNDER};
  assign num_sum  = ({4'd0, acc} * 35'd10) + {31'd0, digit};

  // pending token finished by end of text or a non-extending character
  always_comb begin
    fl_valid = 1'b1;
    fl_bang  = 1'b0;
    fl_tok   = etok_pkg::mk_tok(etok_pkg::TK_EOF, 31'd0, 16'd0, 16'd0, line_cnt);
    case (mode)
      etok_pkg::MODE_NUM: begin
        fl_tok.token_kind = etok_pkg::TK_INT;
        fl_tok.int_value  = acc;
      end
      etok_pkg::MODE_WORD: begin
        if (wlen == etok_pkg::KW_IF_LEN && kw == etok_pkg::KW_IF) begin
          fl_tok.token_kind = etok_pkg::TK_IF;
        end else if (wlen == etok_pkg::KW_WHILE_LEN && kw == etok_pkg::KW_WHILE) begin
          fl_tok.token_kind = etok_pkg::TK_WHILE;
        end else begin
          fl_tok.token_kind   = etok_pkg::TK_IDENT;
          fl_tok.ident_start  = wstart;
          fl_tok.ident_length = wlen;
        end
      end
      etok_pkg::MODE_EQ: fl_tok.token_kind = etok_pkg::TK_EQ;
      etok_pkg::MODE_LT: fl_tok.token_kind = etok_pkg::TK_LT;
      etok_pkg::MODE_GT: fl_tok.token_kind = etok_pkg::TK_GT;
      etok_pkg::MODE_BANG: begin
        fl_tok.token_kind = etok_pkg::TK_ERROR;
        fl_bang = 1'b1;
      end
      default: fl_valid = 1'b0;
    endcase
  end

  always_comb begin
    mode_next     = mode;
    acc_next      = acc;
    wstart_next   = wstart;
    wlen_next     = wlen;
    kw_next       = kw;
    pos_next      = pos;
    line_cnt_next = line_cnt;
    err_next      = err;
    va     = 1'b0;
    vb     = 1'b0;
    tok_a  = fl_tok;
    tok_b  = etok_pkg::mk_tok(etok_pkg::TK_EOF, 31'd0, 16'd0, 16'd0, line_cnt);
    extend = 1'b0;
    if (err) begin
      vb = 1'b1;
      tok_b.token_kind = etok_pkg::TK_ERROR;
    end else if (text.action) begin
      va = fl_valid;
      mode_next = etok_pkg::MODE_IDLE;
      if (fl_bang) begin
        err_next = 1'b1;
      end else begin
        vb = 1'b1;
        pos_next = 16'd0;
        line_cnt_next = 16'd1;
      end
    end else begin
      if (pos < etok_pkg::POS_LIMIT) begin
        pos_next = pos + 16'd1;
      end
      case (mode)
        etok_pkg::MODE_NUM: begin
          if (is_digit) begin
            extend = 1'b1;
            acc_next = (num_sum > {4'd0, etok_pkg::INT_MAX31}) ? etok_pkg::INT_MAX31
                                                                : num_sum[30:0];
          end
        end
        etok_pkg::MODE_WORD: begin
          if (is_alpha || is_digit) begin
            extend = 1'b1;
            if (wlen < etok_pkg::KW_WHILE_LEN) begin
              kw_next = {kw[31:0], c};
            end
            if (wlen != etok_pkg::SAT16) begin
              wlen_next = wlen + 16'd1;
            end
          end
        end
        etok_pkg::MODE_EQ, etok_pkg::MODE_LT, etok_pkg::MODE_GT, etok_pkg::MODE_BANG: begin
          if (c == etok_pkg::CH_EQUAL) begin
            extend = 1'b1;
            mode_next = etok_pkg::MODE_IDLE;
            vb = 1'b1;
            case (mode)
              etok_pkg::MODE_EQ: tok_b.token_kind = etok_pkg::TK_EE;
              etok_pkg::MODE_LT: tok_b.token_kind = etok_pkg::TK_LE;
              etok_pkg::MODE_GT: tok_b.token_kind = etok_pkg::TK_GE;
              default:           tok_b.token_kind = etok_pkg::TK_NE;
            endcase
          end
        end
        default: ;
      endcase
      if (!extend) begin
        va = fl_valid;
        mode_next = etok_pkg::MODE_IDLE;
        if (fl_bang) begin
          err_next = 1'b1;
        end else begin
          case (c)
            etok_pkg::CH_SPACE, etok_pkg::CH_TAB, etok_pkg::CH_VT,
            etok_pkg::CH_FF, etok_pkg::CH_CR: ;
            etok_pkg::CH_NL: begin
              vb = 1'b1;
              tok_b.token_kind = etok_pkg::TK_NEWLINE;
              if (line_cnt != etok_pkg::SAT16) begin
                line_cnt_next = line_cnt + 16'd1;
              end
            end
            etok_pkg::CH_PLUS:   begin vb = 1'b1; tok_b.token_kind = etok_pkg::TK_PLUS;   end
            etok_pkg::CH_MINUS:  begin vb = 1'b1; tok_b.token_kind = etok_pkg::TK_MINUS;  end
            etok_pkg::CH_STAR:   begin vb = 1'b1; tok_b.token_kind = etok_pkg::TK_MUL;    end
            etok_pkg::CH_SLASH:  begin vb = 1'b1; tok_b.token_kind = etok_pkg::TK_DIV;    end
            etok_pkg::CH_LPAREN: begin vb = 1'b1; tok_b.token_kind = etok_pkg::TK_LPAREN; end
            etok_pkg::CH_RPAREN: begin vb = 1'b1; tok_b.token_kind = etok_pkg::TK_RPAREN; end
            etok_pkg::CH_COLON:  begin vb = 1'b1; tok_b.token_kind = etok_pkg::TK_COLON;  end
            etok_pkg::CH_EQUAL:  mode_next = etok_pkg::MODE_EQ;
            etok_pkg::CH_LESS:   mode_next = etok_pkg::MODE_LT;
            etok_pkg::CH_GREAT:  mode_next = etok_pkg::MODE_GT;
            etok_pkg::CH_BANG:   mode_next = etok_pkg::MODE_BANG;
            default: begin
              if (is_digit) begin
                mode_next = etok_pkg::MODE_NUM;
                acc_next  = {27'd0, digit};
              end else if (is_alpha) begin
                mode_next   = etok_pkg::MODE_WORD;
                wstart_next = pos;
                wlen_next   = 16'd1;
                kw_next     = {32'd0, c};
              end else begin
                vb = 1'b1;
                tok_b.token_kind = etok_pkg::TK_ERROR;
                err_next = 1'b1;
              end
            end
          endcase
        end
      end
    end
  end

  // pack the results to the front and mark the last one
  always_comb begin
    r0 = va ? tok_a : tok_b;
    r1 = tok_b;
    push0 = accept && (va || vb);
    push1 = accept && va && vb;
    r0.last_of_run = !(va && vb);
    r1.last_of_run = 1'b1;
  end

  always_comb begin
    base_cnt = count - {2'd0, pop};
    for (int i = 0; i < 4; i++) begin
      q_next[i] = (pop && i < 3) ? q[(i < 3) ? i + 1 : i] : q[i];
      if (push0 && base_cnt == 3'(i)) begin
        q_next[i] = r0;
      end
      if (push1 && base_cnt + 3'd1 == 3'(i)) begin
        q_next[i] = r1;
      end
    end
    count_next = base_cnt + {2'd0, push0} + {2'd0, push1};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      q[i] <= q_next[i];
    end
    if (rst) begin
      count    <= 3'd0;
      mode     <= etok_pkg::MODE_IDLE;
      acc      <= 31'd0;
      wstart   <= 16'd0;
      wlen     <= 16'd0;
      kw       <= 40'd0;
      pos      <= 16'd0;
      line_cnt <= 16'd1;
      err      <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        mode     <= mode_next;
        acc      <= acc_next;
        wstart   <= wstart_next;
        wlen     <= wlen_next;
        kw       <= kw_next;
        pos      <= pos_next;
        line_cnt <= line_cnt_next;
        err      <= err_next;
      end
    end
  end

  assign tokens.valid        = (count != 3'd0);
  assign tokens.token_kind   = q[0].token_kind;
  assign tokens.int_value    = q[0].int_value;
  assign tokens.ident_start  = q[0].ident_start;
  assign tokens.ident_length = q[0].ident_length;
  assign tokens.line_number  = q[0].line_number;
  assign tokens.last_of_run  = q[0].last_of_run;

  assert property (@(posedge clk) disable iff (rst) count <= etok_pkg::QUEUE_DEPTH)
    else $error("token queue overflow");

  assert property (@(posedge clk) disable iff (rst) err |-> mode == etok_pkg::MODE_IDLE)
    else $error("scan mode active after error");

  assert property (@(posedge clk) disable iff (rst) line_cnt != 16'd0)
    else $error("line counter reached zero");

  assert property (@(posedge clk) disable iff (rst)
                   (count == 3'd1 && pop && !accept) |=> !tokens.valid)
    else $error("token shown after queue drained");

endmodule

### verif/expression_tokenizer_unit_tb.sv
// Self-checking testbench of expression_tokenizer_unit against a token predictor.
module expression_tokenizer_unit_tb;

  localparam int DEFAULT_IDLE_PCT = 31;
  localparam int HOLD_CYCLES      = 400;
  localparam int RANDOM_BEATS     = 970;
  localparam int FULL_RATE_BEATS  = 200;
  localparam int LONG_WORD_CHARS  = 40;
  localparam int LONG_NEWLINES    = 20;

  logic clk = 1'b0;
  logic rst;
  logic hold_on = 1'b0;
  event hold_go;

  etok_in_if  text_if();
  etok_out_if tokens_if();

  expression_tokenizer_unit dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_if),
    .tokens (tokens_if)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [2:0]  mode;
  logic [30:0] num_acc;
  logic [15:0] word_pos;
  logic [15:0] word_len;
  logic [39:0] word_head;
  logic [15:0] char_pos;
  logic [15:0] line_count;
  logic        error_latched;

  etok_pkg::tok_t expected_tokens[$];
  int   failures = 0;
  int   beats_sent = 0;
  int   tokens_checked = 0;
  int   src_idle_pct = DEFAULT_IDLE_PCT;
  int   sink_idle_pct = DEFAULT_IDLE_PCT;

  function automatic bit is_digit(logic [7:0] c);
    return c >= etok_pkg::CH_ZERO && c <= etok_pkg::CH_NINE;
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= etok_pkg::CH_LOW_A && c <= etok_pkg::CH_LOW_Z) ||
           (c >= etok_pkg::CH_UP_A && c <= etok_pkg::CH_UP_Z) || c == etok_pkg::CH_UNDER;
  endfunction

  function automatic bit is_lexable(logic [7:0] c);
    return is_digit(c) || is_alpha(c) ||
      c inside {etok_pkg::CH_SPACE, etok_pkg::CH_TAB, etok_pkg::CH_VT, etok_pkg::CH_FF,
                etok_pkg::CH_CR, etok_pkg::CH_NL, etok_pkg::CH_PLUS, etok_pkg::CH_MINUS,
                etok_pkg::CH_STAR, etok_pkg::CH_SLASH, etok_pkg::CH_LPAREN,
                etok_pkg::CH_RPAREN, etok_pkg::CH_COLON, etok_pkg::CH_EQUAL,
                etok_pkg::CH_LESS, etok_pkg::CH_GREAT, etok_pkg::CH_BANG};
  endfunction

  function automatic void push_token(logic [4:0] kind, logic [30:0] val = '0,
                                     logic [15:0] start = '0, logic [15:0] len = '0);
    etok_pkg::tok_t t;
    t.token_kind   = kind;
    t.int_value    = val;
    t.ident_start  = start;
    t.ident_length = len;
    t.line_number  = line_count;
    t.last_of_run  = 1'b0;
    expected_tokens.push_back(t);
  endfunction

  function automatic void latch_error();
    error_latched = 1'b1;
    mode = etok_pkg::MODE_IDLE;
    push_token(etok_pkg::TK_ERROR);
  endfunction

  // close the pending token; return 0 when it turned into an error
  function automatic bit close_pending();
    logic [2:0] m;
    m = mode;
    mode = etok_pkg::MODE_IDLE;
    case (m)
      etok_pkg::MODE_NUM: push_token(etok_pkg::TK_INT, num_acc);
      etok_pkg::MODE_WORD: begin
        if (word_len == etok_pkg::KW_IF_LEN && word_head == etok_pkg::KW_IF)
          push_token(etok_pkg::TK_IF);
        else if (word_len == etok_pkg::KW_WHILE_LEN && word_head == etok_pkg::KW_WHILE)
          push_token(etok_pkg::TK_WHILE);
        else push_token(etok_pkg::TK_IDENT, '0, word_pos, word_len);
      end
      etok_pkg::MODE_EQ: push_token(etok_pkg::TK_EQ);
      etok_pkg::MODE_LT: push_token(etok_pkg::TK_LT);
      etok_pkg::MODE_GT: push_token(etok_pkg::TK_GT);
      etok_pkg::MODE_BANG: begin
        latch_error();
        return 1'b0;
      end
      default: ;
    endcase
    return 1'b1;
  endfunction

  function automatic void open_token(logic [7:0] c);
    case (c)
      etok_pkg::CH_SPACE, etok_pkg::CH_TAB, etok_pkg::CH_VT, etok_pkg::CH_FF,
      etok_pkg::CH_CR: ;
      etok_pkg::CH_NL: begin
        push_token(etok_pkg::TK_NEWLINE);
        if (line_count != etok_pkg::SAT16) line_count++;
      end
      etok_pkg::CH_PLUS:   push_token(etok_pkg::TK_PLUS);
      etok_pkg::CH_MINUS:  push_token(etok_pkg::TK_MINUS);
      etok_pkg::CH_STAR:   push_token(etok_pkg::TK_MUL);
      etok_pkg::CH_SLASH:  push_token(etok_pkg::TK_DIV);
      etok_pkg::CH_LPAREN: push_token(etok_pkg::TK_LPAREN);
      etok_pkg::CH_RPAREN: push_token(etok_pkg::TK_RPAREN);
      etok_pkg::CH_COLON:  push_token(etok_pkg::TK_COLON);
      etok_pkg::CH_EQUAL:  mode = etok_pkg::MODE_EQ;
      etok_pkg::CH_LESS:   mode = etok_pkg::MODE_LT;
      etok_pkg::CH_GREAT:  mode = etok_pkg::MODE_GT;
      etok_pkg::CH_BANG:   mode = etok_pkg::MODE_BANG;
      default: begin
        if (is_digit(c)) begin
          mode = etok_pkg::MODE_NUM;
          num_acc = 31'(c - etok_pkg::CH_ZERO);
        end else if (is_alpha(c)) begin
          mode = etok_pkg::MODE_WORD;
          word_pos = char_pos;
          word_len = 16'd1;
          word_head = 40'(c);
        end else begin
          latch_error();
        end
      end
    endcase
  endfunction

  function automatic void scan_char(logic [7:0] c);
    logic [63:0] grown;
    logic [4:0]  kind;
    case (mode)
      etok_pkg::MODE_NUM: begin
        if (is_digit(c)) begin
          grown = 64'(num_acc) * 64'd10 + 64'(c - etok_pkg::CH_ZERO);
          num_acc = (grown > 64'(etok_pkg::INT_MAX31)) ? etok_pkg::INT_MAX31 : grown[30:0];
          return;
        end
      end
      etok_pkg::MODE_WORD: begin
        if (is_alpha(c) || is_digit(c)) begin
          if (word_len < etok_pkg::KW_WHILE_LEN) word_head = {word_head[31:0], c};
          if (word_len != etok_pkg::SAT16) word_len++;
          return;
        end
      end
      etok_pkg::MODE_EQ, etok_pkg::MODE_LT, etok_pkg::MODE_GT, etok_pkg::MODE_BANG: begin
        if (c == etok_pkg::CH_EQUAL) begin
          case (mode)
            etok_pkg::MODE_EQ: kind = etok_pkg::TK_EE;
            etok_pkg::MODE_LT: kind = etok_pkg::TK_LE;
            etok_pkg::MODE_GT: kind = etok_pkg::TK_GE;
            default: kind = etok_pkg::TK_NE;
          endcase
          mode = etok_pkg::MODE_IDLE;
          push_token(kind);
          return;
        end
      end
      default: ;
    endcase
    if (!close_pending()) return;
    open_token(c);
  endfunction

  function automatic void predict_tokens(logic act, logic [7:0] c);
    int   n_prior;
    etok_pkg::tok_t t;
    n_prior = expected_tokens.size();
    if (error_latched) begin
      push_token(etok_pkg::TK_ERROR);
    end else if (act) begin
      if (close_pending()) begin
        push_token(etok_pkg::TK_EOF);
        char_pos = '0;
        line_count = 16'd1;
      end
    end else begin
      scan_char(c);
      if (char_pos < etok_pkg::POS_LIMIT) char_pos++;
    end
    if (expected_tokens.size() > n_prior) begin
      t = expected_tokens.pop_back();
      t.last_of_run = 1'b1;
      expected_tokens.push_back(t);
    end
  endfunction

  function automatic logic [7:0] rand_alpha();
    int r;
    r = $urandom_range(52);
    if (r < 26) return etok_pkg::CH_LOW_A + 8'(r);
    if (r < 52) return etok_pkg::CH_UP_A + 8'(r - 26);
    return etok_pkg::CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_digit();
    return etok_pkg::CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(3) == 0) ? rand_digit() : rand_alpha();
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(4))
      0: return etok_pkg::CH_SPACE;
      1: return etok_pkg::CH_TAB;
      2: return etok_pkg::CH_VT;
      3: return etok_pkg::CH_FF;
      default: return etok_pkg::CH_CR;
    endcase
  endfunction

  task automatic send_beat(input logic act, input logic [7:0] c);
    while ($urandom_range(99) < src_idle_pct) begin
      text_if.valid <= 1'b0;
      text_if.char_byte <= 8'($urandom);
      @(posedge clk);
    end
    text_if.valid <= 1'b1;
    text_if.action <= act;
    text_if.char_byte <= c;
    @(posedge clk);
    while (!text_if.ready) @(posedge clk);
    predict_tokens(act, c);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(1'b0, s[i]);
  endtask

  task automatic send_end();
    send_beat(1'b1, 8'($urandom));
  endtask

  task automatic wait_for_tokens();
    text_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_lexeme();
    int    pick;
    int    n;
    string ops;
    pick = $urandom_range(99);
    ops = "+-*/():=<>";
    if (pick < 24) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(14, 10) : $urandom_range(4, 1);
      repeat (n) send_beat(1'b0, rand_digit());
    end else if (pick < 48) begin
      case ($urandom_range(7))
        0: send_text("if");
        1: send_text("while");
        2: send_text("whil");
        3: send_text("whileX");
        4: send_text("iF");
        default: begin
          n = $urandom_range(8, 1);
          send_beat(1'b0, rand_alpha());
          repeat (n - 1) send_beat(1'b0, rand_alnum());
        end
      endcase
    end else if (pick < 74) begin
      case ($urandom_range(5))
        0: send_text("==");
        1: send_text("<=");
        2: send_text(">=");
        3: send_text("!=");
        default: send_beat(1'b0, ops[$urandom_range(ops.len() - 1)]);
      endcase
    end else if (pick < 88) begin
      send_beat(1'b0, rand_space());
    end else if (pick < 96) begin
      send_beat(1'b0, etok_pkg::CH_NL);
    end else begin
      send_end();
    end
    if ($urandom_range(1)) send_beat(1'b0, rand_space());
  endtask

  task automatic run_random_text(input int n_beats);
    int start;
    start = beats_sent;
    while (beats_sent - start < n_beats) send_random_lexeme();
  endtask

  task automatic test_directed_tokens();
    send_text("if(while)_9");
    send_beat(1'b0, etok_pkg::CH_TAB);
    send_beat(1'b0, etok_pkg::CH_VT);
    send_beat(1'b0, etok_pkg::CH_FF);
    send_beat(1'b0, etok_pkg::CH_CR);
    send_text("9999999999*/:+-==<=>=!==<>+\nA");
    send_end();
    send_end();
  endtask

  task automatic test_random_text();
    run_random_text(RANDOM_BEATS);
  endtask

  task automatic test_full_rate();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    run_random_text(FULL_RATE_BEATS);
    src_idle_pct = DEFAULT_IDLE_PCT;
    sink_idle_pct = DEFAULT_IDLE_PCT;
  endtask

  task automatic test_token_backpressure();
    -> hold_go;
    repeat (60) begin
      if ($urandom_range(1)) send_beat(1'b0, etok_pkg::CH_NL);
      else send_text("=+");
    end
  endtask

  task automatic test_pause_mid_token();
    send_text("x12 <");
    wait_for_tokens();
    send_text("= 4711");
    wait_for_tokens();
    send_text("9 whi");
    wait_for_tokens();
    send_text("le\n");
    send_end();
  endtask

  task automatic test_long_tokens();
    send_end();
    send_beat(1'b0, rand_alpha());
    repeat (LONG_WORD_CHARS - 1) send_beat(1'b0, rand_alnum());
    send_text(" q\n");
    repeat (LONG_NEWLINES) send_beat(1'b0, etok_pkg::CH_NL);
    send_text("99999999999999 ");
    send_end();
  endtask

  task automatic test_sticky_error();
    logic [7:0] c;
    send_text("x1 <");
    case ($urandom_range(2))
      0: begin
        send_beat(1'b0, etok_pkg::CH_BANG);
        do c = 8'($urandom); while (c == etok_pkg::CH_EQUAL);
        send_beat(1'b0, c);
      end
      1: begin
        send_beat(1'b0, etok_pkg::CH_BANG);
        send_end();
      end
      default: begin
        do c = 8'($urandom); while (is_lexable(c));
        send_beat(1'b0, c);
      end
    endcase
    repeat (40) send_beat(1'($urandom_range(1)), 8'($urandom));
  endtask

  // receiver: random stalls plus one long hold
  always begin
    @(hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    tokens_if.ready <= !hold_on && ($urandom_range(99) >= sink_idle_pct);
  end

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    etok_pkg::tok_t want;
    if (!rst && tokens_if.valid && tokens_if.ready) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected token, expected none, got kind %0d",
                 $time, tokens_if.token_kind);
        failures++;
      end else begin
        want = expected_tokens.pop_front();
        check_field("token_kind", want.token_kind, tokens_if.token_kind);
        check_field("int_value", want.int_value, tokens_if.int_value);
        check_field("ident_start", want.ident_start, tokens_if.ident_start);
        check_field("ident_length", want.ident_length, tokens_if.ident_length);
        check_field("line_number", want.line_number, tokens_if.line_number);
        check_field("last_of_run", want.last_of_run, tokens_if.last_of_run);
        tokens_checked++;
      end
    end
  end

  initial begin
    #400000;
    $display("expression_tokenizer_unit regression: fail");
    $finish;
  end

  initial begin
    mode = etok_pkg::MODE_IDLE;
    num_acc = '0;
    word_pos = '0;
    word_len = '0;
    word_head = '0;
    char_pos = '0;
    line_count = 16'd1;
    error_latched = 1'b0;
    rst <= 1'b1;
    text_if.valid <= 1'b0;
    text_if.action <= 1'b0;
    text_if.char_byte <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed_tokens();
    test_random_text();
    test_full_rate();
    test_token_backpressure();
    test_pause_mid_token();
    test_long_tokens();
    run_random_text(100);
    test_sticky_error();

    wait_for_tokens();
    repeat (16) @(posedge clk);
    $display("sent %0d text beats and checked %0d tokens, covering every token kind,",
             beats_sent, tokens_checked);
    $display("number saturation, long words, a long output stall and a sticky error");
    if (failures == 0) $display("expression_tokenizer_unit regression: pass");
    else $display("expression_tokenizer_unit regression: fail");
    $finish;
  end

endmodule

### sim.f
design/etok_pkg.sv
design/etok_in_if.sv
design/etok_out_if.sv
design/expression_tokenizer_unit.sv
verif/expression_tokenizer_unit_tb.sv
